>>> rtl/core/fftm_pkg.sv
// ----------------------------------------------------------------------------
// fftm_pkg
// Shared constants, types and helper functions of the FFT magnitude block.
// ----------------------------------------------------------------------------
package fftm_pkg;

  localparam int POINTS      = 64;
  localparam int LOG2_POINTS = $clog2(POINTS);
  localparam int ADDR_W      = LOG2_POINTS;
  localparam int K_W         = LOG2_POINTS - 1;
  localparam int STAGE_W     = $clog2(LOG2_POINTS);
  localparam int HALF_PTS    = POINTS / 2;
  localparam int QUARTER     = POINTS / 4;

  localparam int SAMPLE_W = 16;
  localparam int DATA_W   = 24;
  localparam int TW_BITS  = 16;
  localparam int TW_FRAC  = TW_BITS - 1;
  localparam int PROD_W   = DATA_W + TW_BITS;
  localparam int ACC_W    = PROD_W + 1;
  localparam int T_W      = ACC_W - TW_FRAC;
  localparam int SUM_W    = T_W + 1;

  localparam int SQ_W        = 2 * DATA_W;
  localparam int SQRT_STEPS  = SQ_W / 2;
  localparam int SQRT_CNT_W  = $clog2(SQRT_STEPS + 1);
  localparam int ROOT_W      = SQRT_STEPS;

  localparam int MAG_W = 22;
  localparam int BIN_W = 6;
  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (TW_FRAC - 1);

  typedef struct packed {
    logic              fill_we;
    logic              bf_mul;
    logic              bf_rnd;
    logic              bf_add;
    logic              bf_wra;
    logic              bf_wrb;
    logic              mag_sq;
    logic              mag_sum;
    logic              sqrt_step;
    logic              out_load;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [K_W-1:0]    k;
  } fftm_cmd_t;

  typedef struct packed {
    logic sqrt_done;
  } fftm_status_t;

  // Cosine of 2*pi*q/POINTS for the first quarter turn, Q1.15, clamped.
  function automatic logic signed [TW_BITS-1:0] quarter_cos(input logic [K_W-1:0] q);
    logic signed [TW_BITS-1:0] r;
    unique case (q)
      5'd0:    r = 16'sd32767;
      5'd1:    r = 16'sd32610;
      5'd2:    r = 16'sd32138;
      5'd3:    r = 16'sd31357;
      5'd4:    r = 16'sd30274;
      5'd5:    r = 16'sd28899;
      5'd6:    r = 16'sd27246;
      5'd7:    r = 16'sd25330;
      5'd8:    r = 16'sd23170;
      5'd9:    r = 16'sd20788;
      5'd10:   r = 16'sd18205;
      5'd11:   r = 16'sd15447;
      5'd12:   r = 16'sd12540;
      5'd13:   r = 16'sd9512;
      5'd14:   r = 16'sd6393;
      5'd15:   r = 16'sd3212;
      default: r = 16'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [TW_BITS-1:0] tw_cos(input logic [K_W-1:0] k);
    logic [K_W-1:0] m;
    m = K_W'(HALF_PTS - int'(k));
    if (int'(k) <= QUARTER) begin
      return quarter_cos(k);
    end
    return -quarter_cos(m);
  endfunction

  function automatic logic signed [TW_BITS-1:0] tw_sin(input logic [K_W-1:0] k);
    logic [K_W-1:0] lo;
    logic [K_W-1:0] hi;
    lo = K_W'(QUARTER - int'(k));
    hi = K_W'(int'(k) - QUARTER);
    if (int'(k) <= QUARTER) begin
      return quarter_cos(lo);
    end
    return quarter_cos(hi);
  endfunction

  function automatic logic [ADDR_W-1:0] bit_rev(input logic [ADDR_W-1:0] v);
    logic [ADDR_W-1:0] r;
    for (int i = 0; i < ADDR_W; i++) begin
      r[i] = v[ADDR_W-1-i];
    end
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] v);
    if (v[SUM_W-1] && !(&v[SUM_W-2:DATA_W-1])) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end
    if (!v[SUM_W-1] && (|v[SUM_W-2:DATA_W-1])) begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

>>> rtl/core/radix2_fft_magnitude.sv
// ----------------------------------------------------------------------------
// radix2_fft_magnitude
// 64-point radix-2 DIT FFT of real samples with per-bin magnitude output.
// ----------------------------------------------------------------------------
// Feed 64 signed 16-bit samples, one per cycle at most; they land in the
// stores in bit-reversed order. After the 64th transfer the input side goes
// not ready while one shared butterfly runs 6 passes of 32 butterflies, each
// in the steps read, multiply, round, add, write a and write b, with 24-bit
// saturating data and Q1.15 twiddles. Then every bin is read, squared and
// rooted one result bit per cycle by a 24-step square-root unit, and held
// until the result side takes it before the next bin starts; bins come in
// ascending order with last_bin_o on bin 63. The serial root and the single
// memory write port limit the frame rate. Input is taken again as soon as
// the last bin transfers.
module radix2_fft_magnitude (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 sample_valid_i,
  output logic                                 sample_ready_o,
  input  logic signed [fftm_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                 result_valid_o,
  input  logic                                 result_ready_i,
  output logic [fftm_pkg::MAG_W-1:0]           magnitude_o,
  output logic [fftm_pkg::BIN_W-1:0]           bin_index_o,
  output logic                                 last_bin_o
);

  fftm_pkg::fftm_cmd_t    cmd;
  fftm_pkg::fftm_status_t status;

  // sequencer: owns both handshakes and all address generation
  fftm_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  // stores, butterfly arithmetic and magnitude unit
  fftm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .magnitude_o (magnitude_o),
    .bin_index_o (bin_index_o),
    .last_bin_o  (last_bin_o)
  );

endmodule

>>> rtl/core/fftm_datapath.sv
// ----------------------------------------------------------------------------
// fftm_datapath
// Sample stores, shared butterfly, squarer and bit-serial square root.
// ----------------------------------------------------------------------------
module fftm_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic signed [fftm_pkg::SAMPLE_W-1:0] sample_i,
  input  fftm_pkg::fftm_cmd_t                  cmd_i,
  output fftm_pkg::fftm_status_t               status_o,
  output logic [fftm_pkg::MAG_W-1:0]           magnitude_o,
  output logic [fftm_pkg::BIN_W-1:0]           bin_index_o,
  output logic                                 last_bin_o
);

  localparam int DW = fftm_pkg::DATA_W;

  logic signed [DW-1:0] re_mem [fftm_pkg::POINTS];
  logic signed [DW-1:0] im_mem [fftm_pkg::POINTS];

  logic signed [DW-1:0] ra_re_q, ra_im_q, rb_re_q, rb_im_q;

  logic                              wr_en;
  logic [fftm_pkg::ADDR_W-1:0]       wr_addr;
  logic signed [DW-1:0]              wr_re, wr_im;

  logic signed [DW-1:0] na_re_q, na_im_q, nb_re_q, nb_im_q;

  // single write port per store: fill, then butterfly results
  always_comb begin
    wr_en   = cmd_i.fill_we | cmd_i.bf_wra | cmd_i.bf_wrb;
    wr_addr = cmd_i.addr_a;
    wr_re   = na_re_q;
    wr_im   = na_im_q;
    priority if (cmd_i.fill_we) begin
      wr_re = DW'(sample_i);
      wr_im = '0;
    end else if (cmd_i.bf_wrb) begin
      wr_addr = cmd_i.addr_b;
      wr_re   = nb_re_q;
      wr_im   = nb_im_q;
    end else begin
      wr_re = na_re_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      re_mem[wr_addr] <= wr_re;
      im_mem[wr_addr] <= wr_im;
    end
    ra_re_q <= re_mem[cmd_i.addr_a];
    ra_im_q <= im_mem[cmd_i.addr_a];
    rb_re_q <= re_mem[cmd_i.addr_b];
    rb_im_q <= im_mem[cmd_i.addr_b];
  end

  // butterfly: products, rounding, add/subtract with saturation
  logic signed [fftm_pkg::TW_BITS-1:0] tw_c, tw_s;
  logic signed [fftm_pkg::PROD_W-1:0]  p_rc_q, p_is_q, p_ic_q, p_rs_q;
  logic signed [fftm_pkg::ACC_W-1:0]   acc_r, acc_i;
  logic signed [fftm_pkg::T_W-1:0]     tr_d, ti_d, tr_q, ti_q;

  assign tw_c = fftm_pkg::tw_cos(cmd_i.k);
  assign tw_s = fftm_pkg::tw_sin(cmd_i.k);

  always_comb begin
    acc_r = fftm_pkg::ACC_W'(p_rc_q) + fftm_pkg::ACC_W'(p_is_q) + fftm_pkg::RND_HALF;
    acc_i = fftm_pkg::ACC_W'(p_ic_q) - fftm_pkg::ACC_W'(p_rs_q) + fftm_pkg::RND_HALF;
    priority if (cmd_i.k == '0) begin
      tr_d = fftm_pkg::T_W'(rb_re_q);
      ti_d = fftm_pkg::T_W'(rb_im_q);
    end else if (int'(cmd_i.k) == fftm_pkg::QUARTER) begin
      tr_d = fftm_pkg::T_W'(rb_im_q);
      ti_d = -fftm_pkg::T_W'(rb_re_q);
    end else begin
      tr_d = acc_r[fftm_pkg::ACC_W-1:fftm_pkg::TW_FRAC];
      ti_d = acc_i[fftm_pkg::ACC_W-1:fftm_pkg::TW_FRAC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bf_mul) begin
      p_rc_q <= fftm_pkg::PROD_W'(rb_re_q) * fftm_pkg::PROD_W'(tw_c);
      p_is_q <= fftm_pkg::PROD_W'(rb_im_q) * fftm_pkg::PROD_W'(tw_s);
      p_ic_q <= fftm_pkg::PROD_W'(rb_im_q) * fftm_pkg::PROD_W'(tw_c);
      p_rs_q <= fftm_pkg::PROD_W'(rb_re_q) * fftm_pkg::PROD_W'(tw_s);
    end
    if (cmd_i.bf_rnd) begin
      tr_q <= tr_d;
      ti_q <= ti_d;
    end
    if (cmd_i.bf_add) begin
      na_re_q <= fftm_pkg::sat_data(fftm_pkg::SUM_W'(ra_re_q) + fftm_pkg::SUM_W'(tr_q));
      na_im_q <= fftm_pkg::sat_data(fftm_pkg::SUM_W'(ra_im_q) + fftm_pkg::SUM_W'(ti_q));
      nb_re_q <= fftm_pkg::sat_data(fftm_pkg::SUM_W'(ra_re_q) - fftm_pkg::SUM_W'(tr_q));
      nb_im_q <= fftm_pkg::sat_data(fftm_pkg::SUM_W'(ra_im_q) - fftm_pkg::SUM_W'(ti_q));
    end
  end

  // magnitude: squares, sum, then one root bit per cycle
  logic signed [fftm_pkg::SQ_W-1:0]  sq_re_q, sq_im_q;
  logic [fftm_pkg::SQ_W-1:0]         rem_q, root_q, bit_q, trial;
  logic [fftm_pkg::SQRT_CNT_W-1:0]   sq_cnt_q;

  assign trial = root_q + bit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mag_sq) begin
      sq_re_q <= fftm_pkg::SQ_W'(ra_re_q) * fftm_pkg::SQ_W'(ra_re_q);
      sq_im_q <= fftm_pkg::SQ_W'(ra_im_q) * fftm_pkg::SQ_W'(ra_im_q);
    end
    if (cmd_i.mag_sum) begin
      rem_q  <= fftm_pkg::SQ_W'(sq_re_q) + fftm_pkg::SQ_W'(sq_im_q);
      root_q <= '0;
      bit_q  <= fftm_pkg::SQ_W'(1) << (fftm_pkg::SQ_W - 2);
    end else if (cmd_i.sqrt_step) begin
      if (rem_q >= trial) begin
        rem_q  <= rem_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_cnt_q <= '0;
    end else if (cmd_i.mag_sum) begin
      sq_cnt_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      sq_cnt_q <= sq_cnt_q + 1'b1;
    end
  end

  assign status_o.sqrt_done = (int'(sq_cnt_q) == fftm_pkg::SQRT_STEPS);

  logic [fftm_pkg::MAG_W-1:0] mag_q;
  logic [fftm_pkg::BIN_W-1:0] bin_q;
  logic                       last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      mag_q  <= (root_q > fftm_pkg::SQ_W'(fftm_pkg::MAG_MAX)) ? fftm_pkg::MAG_MAX
                                                              : root_q[fftm_pkg::MAG_W-1:0];
      bin_q  <= fftm_pkg::BIN_W'(cmd_i.addr_a);
      last_q <= (int'(cmd_i.addr_a) == fftm_pkg::POINTS - 1);
    end
  end

  assign magnitude_o = mag_q;
  assign bin_index_o = bin_q;
  assign last_bin_o  = last_q;

endmodule

>>> rtl/core/fftm_ctrl.sv
// ----------------------------------------------------------------------------
// fftm_ctrl
// Sequencer for frame fill, butterfly passes and magnitude readout.
// ----------------------------------------------------------------------------
module fftm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   sample_valid_i,
  output logic                   sample_ready_o,
  output logic                   result_valid_o,
  input  logic                   result_ready_i,
  input  fftm_pkg::fftm_status_t status_i,
  output fftm_pkg::fftm_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_FILL, S_BF_RD, S_BF_MUL, S_BF_RND, S_BF_ADD, S_BF_WRA, S_BF_WRB,
    S_MAG_RD, S_MAG_SQ, S_MAG_SUM, S_SQRT, S_OUT_WAIT
  } state_e;

  state_e                          state_q;
  logic [fftm_pkg::ADDR_W-1:0]     cnt_q;
  logic [fftm_pkg::STAGE_W-1:0]    stage_q;
  logic [fftm_pkg::K_W-1:0]        bfly_q;
  logic                            out_valid_q;

  logic [fftm_pkg::ADDR_W-1:0] bf_ext, bf_mask, bf_a, bf_b, bf_j;

  always_comb begin
    bf_ext  = fftm_pkg::ADDR_W'(bfly_q);
    bf_mask = (fftm_pkg::ADDR_W'(1) << stage_q) - 1'b1;
    bf_j    = bf_ext & bf_mask;
    bf_a    = ((bf_ext >> stage_q) << (stage_q + 1'b1)) | bf_j;
    bf_b    = bf_a | (fftm_pkg::ADDR_W'(1) << stage_q);
  end

  assign sample_ready_o = (state_q == S_FILL);
  assign result_valid_o = out_valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.addr_a    = bf_a;
    cmd_o.addr_b    = bf_b;
    cmd_o.k         = fftm_pkg::K_W'(bf_j << (fftm_pkg::K_W - int'(stage_q)));
    cmd_o.bf_mul    = (state_q == S_BF_MUL);
    cmd_o.bf_rnd    = (state_q == S_BF_RND);
    cmd_o.bf_add    = (state_q == S_BF_ADD);
    cmd_o.bf_wra    = (state_q == S_BF_WRA);
    cmd_o.bf_wrb    = (state_q == S_BF_WRB);
    cmd_o.mag_sq    = (state_q == S_MAG_SQ);
    cmd_o.mag_sum   = (state_q == S_MAG_SUM);
    cmd_o.sqrt_step = (state_q == S_SQRT) && !status_i.sqrt_done;
    cmd_o.out_load  = (state_q == S_SQRT) && status_i.sqrt_done;
    if (state_q == S_FILL) begin
      cmd_o.addr_a  = fftm_pkg::bit_rev(cnt_q);
      cmd_o.fill_we = sample_valid_i;
    end else if (state_q == S_MAG_RD || state_q == S_MAG_SQ || state_q == S_MAG_SUM ||
                 state_q == S_SQRT || state_q == S_OUT_WAIT) begin
      cmd_o.addr_a = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      cnt_q       <= '0;
      stage_q     <= '0;
      bfly_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_FILL: begin
          if (sample_valid_i) begin
            cnt_q <= cnt_q + 1'b1;
            if (int'(cnt_q) == fftm_pkg::POINTS - 1) begin
              stage_q <= '0;
              bfly_q  <= '0;
              state_q <= S_BF_RD;
            end
          end
        end
        S_BF_RD:  state_q <= S_BF_MUL;
        S_BF_MUL: state_q <= S_BF_RND;
        S_BF_RND: state_q <= S_BF_ADD;
        S_BF_ADD: state_q <= S_BF_WRA;
        S_BF_WRA: state_q <= S_BF_WRB;
        S_BF_WRB: begin
          if (int'(bfly_q) == fftm_pkg::HALF_PTS - 1) begin
            bfly_q <= '0;
            if (int'(stage_q) == fftm_pkg::LOG2_POINTS - 1) begin
              cnt_q   <= '0;
              state_q <= S_MAG_RD;
            end else begin
              stage_q <= stage_q + 1'b1;
              state_q <= S_BF_RD;
            end
          end else begin
            bfly_q  <= bfly_q + 1'b1;
            state_q <= S_BF_RD;
          end
        end
        S_MAG_RD:  state_q <= S_MAG_SQ;
        S_MAG_SQ:  state_q <= S_MAG_SUM;
        S_MAG_SUM: state_q <= S_SQRT;
        S_SQRT: begin
          if (status_i.sqrt_done) begin
            out_valid_q <= 1'b1;
            state_q     <= S_OUT_WAIT;
          end
        end
        S_OUT_WAIT: begin
          if (result_ready_i) begin
            out_valid_q <= 1'b0;
            cnt_q       <= cnt_q + 1'b1;
            state_q     <= (int'(cnt_q) == fftm_pkg::POINTS - 1) ? S_FILL : S_MAG_RD;
          end
        end
        default: state_q <= S_FILL;
      endcase
    end
  end

endmodule

>>> rtl/core/fftm_checker.sv
// ----------------------------------------------------------------------------
// fftm_checker
// Port-level checks of the FFT magnitude block, bound to the top level.
// ----------------------------------------------------------------------------
module fftm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          sample_ready_o,
  input logic                          result_valid_o,
  input logic                          result_ready_i,
  input logic [fftm_pkg::MAG_W-1:0]    magnitude_o,
  input logic [fftm_pkg::BIN_W-1:0]    bin_index_o,
  input logic                          last_bin_o
);

  // no sample is taken while a bin is on offer
  a_no_fill_on_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !sample_ready_o)
    else $error("input ready while a result is pending");

  a_last_is_top_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_bin_o |-> bin_index_o == fftm_pkg::BIN_W'(fftm_pkg::POINTS - 1))
    else $error("last bin flag on wrong bin");

  // after a non-final bin the block stays busy with the next one
  a_busy_mid_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_ready_i && !last_bin_o |=> !sample_ready_o && !result_valid_o)
    else $error("frame readout broke off early");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_ready_i |=> result_valid_o && $stable(magnitude_o))
    else $error("stalled result changed");

endmodule

bind radix2_fft_magnitude fftm_checker u_fftm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .sample_ready_o (sample_ready_o),
  .result_valid_o (result_valid_o),
  .result_ready_i (result_ready_i),
  .magnitude_o    (magnitude_o),
  .bin_index_o    (bin_index_o),
  .last_bin_o     (last_bin_o)
);
